// ===== rtl/ttpsc_pkg.sv =====
// Shared types and constants for the tap tempo / patch switch clock unit.
// No dependencies.
package ttpsc_pkg;

	localparam int MAX_PATCHES_DEF = 128;
	localparam int MAX_BPM_DEF     = 1000;

	localparam int US_PER_MINUTE  = 60000000;
	localparam int TICKS_PER_BEAT = 24;
	localparam int US_PER_TICKMIN = US_PER_MINUTE / TICKS_PER_BEAT;
	localparam int RESET_TEMPO    = 120;
	localparam int RESET_TRIM     = 2000;
	localparam int RESET_PATCHES  = 4;
	localparam int RESET_IV       = US_PER_TICKMIN / RESET_TEMPO;

	// divider dividend width covers 60000000
	localparam int DIV_W = 26;
	localparam int IV_W  = 22;

	typedef struct packed {
		logic [31:0] now_us;
		logic        button_a;
		logic        button_b;
	} item_t;

	typedef struct packed {
		logic       clock_pulse;
		logic       send_patch;
		logic [6:0] send_index;
		logic       preview_update;
		logic [6:0] preview_index;
		logic [9:0] tempo_bpm;
	} result_t;

	typedef enum logic [1:0] {
		BTN_NONE = 2'd0,
		BTN_A    = 2'd1,
		BTN_B    = 2'd2
	} btn_class_t;

	typedef struct packed {
		logic [31:0] now_us;
		btn_class_t  cls;
	} cmd_t;

	typedef enum logic {
		CFG_PATCH_COUNT = 1'b0,
		CFG_CLOCK_TRIM  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic       wr;
		cfg_index_t index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/ttpsc_fifo.sv =====
// Two-entry register queue, generic width.
// No package dependencies.
module ttpsc_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== rtl/ttpsc_front.sv =====
// Front end: button press classification with latched levels.
// Depends on ttpsc_pkg.
module ttpsc_front import ttpsc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output cmd_t  cmd
);
	logic held_a_q;
	logic held_b_q;
	logic ignore;

	// a press while its latch is still set blocks both buttons
	assign ignore = (item.button_a && held_a_q) || (item.button_b && held_b_q);

	always_comb begin
		cmd.now_us = item.now_us;
		if (ignore) begin
			cmd.cls = BTN_NONE;
		end else if (item.button_a) begin
			cmd.cls = BTN_A;
		end else if (item.button_b) begin
			cmd.cls = BTN_B;
		end else begin
			cmd.cls = BTN_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_a_q <= 1'b0;
			held_b_q <= 1'b0;
		end else if (accept && !ignore) begin
			held_a_q <= item.button_a;
			held_b_q <= item.button_b;
		end
	end
endmodule

// ===== rtl/ttpsc_div.sv =====
// Restoring divider, one quotient bit per cycle, DIV_W-bit dividend.
// Depends on ttpsc_pkg.
module ttpsc_div import ttpsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DIV_W);

	logic [31:0]      rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [31:0]      div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [32:0]      sh;
	logic             ge;
	logic [31:0]      diff;

	assign sh       = {rem_q, quo_q[DIV_W-1]};
	assign ge       = (sh >= {1'b0, div_q});
	// when ge holds the difference is below the divisor and fits 32 bits
	assign diff     = sh[31:0] - div_q;
	assign done     = busy_q && (cnt_q == CNT_W'(DIV_W - 1));
	assign quotient = {quo_q[DIV_W-2:0], ge};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : sh[31:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end
endmodule

// ===== rtl/ttpsc_back.sv =====
// Back end: clock schedule, patch preview/commit, tap tempo with shared divider.
// Depends on ttpsc_pkg and ttpsc_div.
module ttpsc_back import ttpsc_pkg::*; #(
	parameter int MAX_PATCHES = MAX_PATCHES_DEF,
	parameter int MAX_BPM     = MAX_BPM_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    cmd_empty,
	input  cmd_t    cmd,
	output logic    cmd_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);
	localparam int PATCH_LIM = (MAX_PATCHES > 128) ? 128 : MAX_PATCHES;
	localparam int TEMPO_CAP = (MAX_BPM > 1023) ? 1023 : MAX_BPM;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_TEMPO = 3'b010,
		ST_IV    = 3'b100
	} state_t;

	state_t           state_q;
	logic [7:0]       patch_count_q;
	logic [15:0]      trim_q;
	logic [6:0]       preview_q;
	logic [6:0]       active_q;
	logic [9:0]       tempo_q;
	logic [IV_W-1:0]  iv_q;
	logic [31:0]      due_q;
	logic [31:0]      first_tap_q;
	result_t          pend_q;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [31:0]      div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	logic             take;
	logic             pulse;
	logic [IV_W-1:0]  iv_net;
	logic [7:0]       lim;
	logic [7:0]       nxt;
	logic [6:0]       preview_n;
	logic             is_adv;
	logic             is_commit;
	logic             is_tap;
	logic             tap_second;
	logic [31:0]      span;
	logic [9:0]       tap_tempo;
	result_t          res_now;

	ttpsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign take    = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign cmd_pop = take;

	assign pulse  = (cmd.now_us >= due_q);
	assign iv_net = (iv_q > IV_W'(trim_q)) ? (iv_q - IV_W'(trim_q)) : '0;

	always_comb begin
		lim = (patch_count_q > 8'(PATCH_LIM)) ? 8'(PATCH_LIM) : patch_count_q;
		if (lim == 8'd0) lim = 8'd1;
		nxt = {1'b0, preview_q} + 8'd1;
		if (nxt >= lim) nxt = 8'd0;
	end

	assign is_adv     = (cmd.cls == BTN_A);
	assign is_commit  = (cmd.cls == BTN_B) && (active_q != preview_q);
	assign is_tap     = (cmd.cls == BTN_B) && (active_q == preview_q);
	assign tap_second = is_tap && (first_tap_q != 32'd0);
	assign span       = cmd.now_us - first_tap_q;
	assign preview_n  = is_adv ? nxt[6:0] : preview_q;

	// quotient beyond the cap clamps; above one minute of span it floors at 1
	always_comb begin
		if (div_quo > DIV_W'(TEMPO_CAP)) begin
			tap_tempo = 10'(TEMPO_CAP);
		end else if (div_quo == '0) begin
			tap_tempo = 10'd1;
		end else begin
			tap_tempo = div_quo[9:0];
		end
	end

	always_comb begin
		res_now.clock_pulse    = pulse;
		res_now.send_patch     = is_commit;
		res_now.send_index     = is_commit ? preview_q : 7'd0;
		res_now.preview_update = is_adv;
		res_now.preview_index  = preview_n;
		res_now.tempo_bpm      = (tap_second && span == 32'd0) ? 10'(TEMPO_CAP) : tempo_q;
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(US_PER_TICKMIN);
		div_divisor  = {22'd0, tempo_q};
		res_push     = 1'b0;
		res          = res_now;
		unique case (state_q)
			ST_IDLE: begin
				if (take && tap_second) begin
					div_start = 1'b1;
					if (span != 32'd0) begin
						div_dividend = DIV_W'(US_PER_MINUTE);
						div_divisor  = span;
					end else begin
						div_divisor = 32'(TEMPO_CAP);
					end
				end
				res_push = take && !(tap_second && span != 32'd0);
			end
			ST_TEMPO: begin
				res           = pend_q;
				res.tempo_bpm = tap_tempo;
				res_push      = div_done;
				div_start     = div_done;
				div_divisor   = {22'd0, tap_tempo};
			end
			ST_IV: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) pend_q <= res_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			patch_count_q <= 8'(RESET_PATCHES);
			trim_q        <= 16'(RESET_TRIM);
			preview_q     <= '0;
			active_q      <= '0;
			tempo_q       <= 10'(RESET_TEMPO);
			iv_q          <= IV_W'(RESET_IV);
			due_q         <= 32'(RESET_IV);
			first_tap_q   <= '0;
		end else begin
			if (cfg.wr) begin
				unique case (cfg.index)
					CFG_PATCH_COUNT: patch_count_q <= cfg.data[7:0];
					CFG_CLOCK_TRIM:  trim_q        <= cfg.data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (pulse) due_q <= cmd.now_us + 32'(iv_net);
						preview_q <= preview_n;
						if (is_commit) active_q <= preview_q;
						if (is_tap) first_tap_q <= tap_second ? 32'd0 : cmd.now_us;
						if (tap_second) begin
							if (span == 32'd0) begin
								tempo_q <= 10'(TEMPO_CAP);
								state_q <= ST_IV;
							end else begin
								state_q <= ST_TEMPO;
							end
						end
					end
				end
				ST_TEMPO: begin
					if (div_done) begin
						tempo_q <= tap_tempo;
						state_q <= ST_IV;
					end
				end
				ST_IV: begin
					if (div_done) begin
						iv_q    <= div_quo[IV_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/tap_tempo_patch_switch_clock_unit.sv =====
// Top level of the tap tempo / patch switch clock unit.
// Depends on ttpsc_pkg, ttpsc_fifo, ttpsc_front, ttpsc_back.
//
// Each pushed item (timestamp plus two button levels) yields exactly one result.
// An item without a completed tap pair is handled while the back end is idle. The
// second tap of a pair with a nonzero interval holds the back end busy while the
// one-bit-per-cycle divider first derives the tempo (26 steps) and then
// the clock tick interval (26 steps) before the next item is taken; its result
// leaves once the tempo is known. A second tap with a zero interval skips the
// tempo division. Two-entry queues sit before and after the back end.
// Configuration writes are always ready.
module tap_tempo_patch_switch_clock_unit import ttpsc_pkg::*; #(
	parameter int MAX_PATCHES = MAX_PATCHES_DEF,
	parameter int MAX_BPM     = MAX_BPM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_index_t  cfg_index,
	input  logic [15:0] cfg_data
);
	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_empty;
	logic    cmd_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	cfg_wr_t cfg;
	logic    accept;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_comb begin
		cfg.wr    = cfg_valid && cfg_ready;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	ttpsc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cmd    (cmd_in)
	);

	ttpsc_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	ttpsc_back #(
		.MAX_PATCHES (MAX_PATCHES),
		.MAX_BPM     (MAX_BPM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	ttpsc_fifo #(.WIDTH($bits(result_t))) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);
endmodule
